// ===== rtl/midi_running_status_parser_defines.svh =====
// Assertion macros shared by the MIDI running status parser RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef MIDI_RUNNING_STATUS_PARSER_DEFINES_SVH
`define MIDI_RUNNING_STATUS_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define MRSP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("mrsp assertion failed");
`define MRSP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("mrsp assertion failed");
`else
`define MRSP_ASSERT(label, clk, rstn, prop)
`define MRSP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/mrsp_pkg.sv =====
// Types and constants for the MIDI running status parser.
// No dependencies; imported by mrsp_core, mrsp_out_reg and the top level.
`timescale 1ns / 1ps

package mrsp_pkg;

    typedef enum logic [2:0] {
        KIND_REALTIME = 3'd0,
        KIND_NOTE_OFF = 3'd1,
        KIND_NOTE_ON  = 3'd2,
        KIND_CTRL     = 3'd3,
        KIND_PROGRAM  = 3'd4,
        KIND_BEND     = 3'd5
    } kind_t;

    localparam logic [3:0] GRP_NOTE_OFF = 4'h8;
    localparam logic [3:0] GRP_NOTE_ON  = 4'h9;
    localparam logic [3:0] GRP_POLY_PRS = 4'hA;
    localparam logic [3:0] GRP_CTRL     = 4'hB;
    localparam logic [3:0] GRP_PROGRAM  = 4'hC;
    localparam logic [3:0] GRP_CHAN_PRS = 4'hD;
    localparam logic [3:0] GRP_BEND     = 4'hE;
    localparam logic [3:0] GRP_SYSTEM   = 4'hF;

    localparam logic [7:0] BYTE_REALTIME_MIN = 8'hF8;

    localparam logic [1:0] EXPECT_NONE = 2'd0;
    localparam logic [1:0] EXPECT_ONE  = 2'd1;
    localparam logic [1:0] EXPECT_TWO  = 2'd2;

    typedef struct packed {
        kind_t      kind;
        logic [4:0] channel;
        logic [7:0] first_byte;
        logic [6:0] second_byte;
        logic [7:0] source;
    } msg_t;

endpackage

// ===== rtl/mrsp_in_reg.sv =====
// Input register stage of the MIDI running status parser.
// Depends on nothing beyond the clock and reset.
`timescale 1ns / 1ps

module mrsp_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            data_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

// ===== rtl/mrsp_core.sv =====
// Running status state and message decode for the MIDI parser.
// Depends on mrsp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "midi_running_status_parser_defines.svh"

module mrsp_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          byte_valid,
    input  logic [7:0]    byte_data,
    input  logic          advance,
    input  logic [7:0]    source_tag,
    output logic          res_valid,
    output mrsp_pkg::msg_t res_msg
);
    import mrsp_pkg::*;

    logic [7:0] status_reg;
    logic [7:0] status_next;
    logic [6:0] held_reg;
    logic [6:0] held_next;
    logic [1:0] expect_reg;
    logic [1:0] expect_next;
    logic       seen_reg;
    logic       seen_next;

    logic       fire;
    logic       fin;
    logic [6:0] fin_d1;
    logic [6:0] fin_d2;
    logic       has_res;
    msg_t       msg;

    assign fire = byte_valid && advance;

    always_comb begin
        status_next = status_reg;
        held_next   = held_reg;
        expect_next = expect_reg;
        seen_next   = seen_reg;
        fin         = 1'b0;
        fin_d1      = held_reg;
        fin_d2      = 7'd0;
        priority if (byte_data >= BYTE_REALTIME_MIN) begin
            // realtime leaves the state alone
        end else if (byte_data[7:4] == GRP_SYSTEM) begin
            status_next = 8'd0;
            seen_next   = 1'b0;
            expect_next = EXPECT_NONE;
        end else if (byte_data[7]) begin
            status_next = byte_data;
            seen_next   = 1'b0;
            expect_next = (byte_data[7:4] == GRP_PROGRAM || byte_data[7:4] == GRP_CHAN_PRS)
                          ? EXPECT_ONE : EXPECT_TWO;
        end else if (status_reg == 8'd0) begin
            // data without status is dropped
        end else if (!seen_reg) begin
            held_next = byte_data[6:0];
            if (expect_reg == EXPECT_ONE) begin
                fin    = 1'b1;
                fin_d1 = byte_data[6:0];
            end else begin
                seen_next = 1'b1;
            end
        end else begin
            seen_next = 1'b0;
            fin       = 1'b1;
            fin_d2    = byte_data[6:0];
        end
    end

    always_comb begin
        has_res         = 1'b0;
        msg.kind        = KIND_REALTIME;
        msg.channel     = 5'd0;
        msg.first_byte  = byte_data;
        msg.second_byte = 7'd0;
        msg.source      = source_tag;
        if (byte_data >= BYTE_REALTIME_MIN) begin
            has_res = 1'b1;
        end else if (fin) begin
            msg.channel     = {1'b0, status_reg[3:0]} + 5'd1;
            msg.first_byte  = {1'b0, fin_d1};
            msg.second_byte = fin_d2;
            unique case (status_reg[7:4])
                GRP_NOTE_ON: begin
                    has_res  = 1'b1;
                    msg.kind = (fin_d2 == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
                end
                GRP_NOTE_OFF: begin
                    has_res  = 1'b1;
                    msg.kind = KIND_NOTE_OFF;
                end
                GRP_CTRL: begin
                    has_res  = 1'b1;
                    msg.kind = KIND_CTRL;
                end
                GRP_PROGRAM: begin
                    has_res         = 1'b1;
                    msg.kind        = KIND_PROGRAM;
                    msg.second_byte = 7'd0;
                end
                GRP_BEND: begin
                    has_res  = 1'b1;
                    msg.kind = KIND_BEND;
                end
                default: begin
                    has_res = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= 8'd0;
            expect_reg <= EXPECT_NONE;
            seen_reg   <= 1'b0;
        end else if (fire) begin
            status_reg <= status_next;
            expect_reg <= expect_next;
            seen_reg   <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            held_reg <= held_next;
        end
    end

    assign res_valid = fire && has_res;
    assign res_msg   = msg;

    `MRSP_ASSERT(a_seen_needs_two, aclk, aresetn, seen_reg |-> (status_reg != 8'd0 && expect_reg == EXPECT_TWO))
    `MRSP_ASSERT(a_status_is_channel, aclk, aresetn, (status_reg != 8'd0) |-> (status_reg[7] && status_reg[7:4] != GRP_SYSTEM))
    `MRSP_ASSERT(a_expect_tracks_status, aclk, aresetn, (status_reg == 8'd0) == (expect_reg == EXPECT_NONE))

endmodule

// ===== rtl/mrsp_out_reg.sv =====
// Output register of the MIDI running status parser; drives the result stream.
// Depends on mrsp_pkg.
`timescale 1ns / 1ps

module mrsp_out_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           res_valid,
    input  mrsp_pkg::msg_t res_msg,
    output logic           advance,
    output logic           m_tvalid,
    input  logic           m_tready,
    output mrsp_pkg::msg_t m_msg
);
    import mrsp_pkg::*;

    logic valid_reg;
    logic valid_next;
    msg_t msg_reg;

    assign advance    = !valid_reg || m_tready;
    assign valid_next = advance ? res_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            msg_reg <= res_msg;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_msg    = msg_reg;

endmodule

// ===== rtl/midi_running_status_parser.sv =====
// MIDI byte stream parser with running status: top level.
// Path: each accepted byte is registered in mrsp_in_reg, decoded by mrsp_core, then registered in mrsp_out_reg.
// Throughput: one byte per cycle; the stages advance together when the output is free.
// Reset (aresetn low, synchronous) clears running status, both valids and source_tag.
// Depends on mrsp_pkg, mrsp_in_reg, mrsp_core, mrsp_out_reg and the defines header.
`timescale 1ns / 1ps
`include "midi_running_status_parser_defines.svh"

module midi_running_status_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] channel, [12:5] first_byte, [19:13] second_byte, [27:20] source, [31:28] zero
    output logic [31:0] m_tdata,
    output logic [2:0]  m_tuser    // [2:0] kind
);
    import mrsp_pkg::*;

    logic [7:0] source_tag_reg;
    logic       advance;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       res_valid;
    msg_t       res_msg;
    msg_t       m_msg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_tag_reg <= 8'd0;
        end else if (cfg_wr_en) begin
            source_tag_reg <= cfg_wr_data;
        end
    end

    mrsp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    mrsp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .advance    (advance),
        .source_tag (source_tag_reg),
        .res_valid  (res_valid),
        .res_msg    (res_msg)
    );

    mrsp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_msg   (res_msg),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_msg     (m_msg)
    );

    assign m_tuser = m_msg.kind;
    assign m_tdata = {4'd0, m_msg.source, m_msg.second_byte, m_msg.first_byte, m_msg.channel};

    `MRSP_ASSERT(a_realtime_fields, aclk, aresetn, (m_tvalid && m_tuser == KIND_REALTIME) |-> (m_tdata[4:0] == 5'd0 && m_tdata[12:10] == 3'b111 && m_tdata[19:13] == 7'd0))
    `MRSP_ASSERT(a_channel_range, aclk, aresetn, (m_tvalid && m_tuser != KIND_REALTIME) |-> (m_tdata[4:0] != 5'd0 && m_tdata[12] == 1'b0))

endmodule
